@@ src/csit_pkg.sv @@
// ----------------------------------------------------------------------------
// csit_pkg: shared types for the cost sorted insert table
// Command and status codes, the entry layout and the per-cell control word.
// ----------------------------------------------------------------------------
`default_nettype none

package csit_pkg;

   localparam int COST_W   = 24;
   localparam int HANDLE_W = 16;
   localparam int INDEX_W  = 7;
   localparam int COUNT_W  = 8;

   typedef enum logic [1:0] {
      CMD_INSERT = 2'd0,
      CMD_REMOVE = 2'd1,
      CMD_READ   = 2'd2,
      CMD_NOP    = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      STAT_OK     = 2'd0,
      STAT_EVICT  = 2'd1,
      STAT_REJECT = 2'd2,
      STAT_RANGE  = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      OP_HOLD   = 2'd0,
      OP_INSERT = 2'd1,
      OP_REMOVE = 2'd2
   } cell_op_type;

   typedef struct packed {
      logic [COST_W-1:0]   cost;
      logic [HANDLE_W-1:0] handle;
   } entry_type;

   typedef struct packed {
      cell_op_type op;
      entry_type   entry;
   } cell_ctrl_type;

endpackage

`default_nettype wire

@@ src/csit_cell.sv @@
// ----------------------------------------------------------------------------
// csit_cell: one table slot
// Holds one entry, compares it with the new cost, and shifts right on insert
// or left on remove. Drives its entry onto the read tap when addressed.
// ----------------------------------------------------------------------------
`default_nettype none

module csit_cell #(
   parameter int CAPACITY = 128,
   parameter int INDEX    = 0
) (
   input  wire                          clock,
   input  csit_pkg::cell_ctrl_type      ctrl,
   input  wire [$clog2(CAPACITY+1)-1:0] count,
   input  wire [$clog2(CAPACITY)-1:0]   idx,
   input  csit_pkg::entry_type          left_entry,
   input  wire                          left_keep,
   input  csit_pkg::entry_type          right_entry,
   output csit_pkg::entry_type          entry,
   output logic                         keep,
   output logic                         take_new,
   output csit_pkg::entry_type          tap
);

   localparam int IW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY+1);

   csit_pkg::entry_type entry_ff;
   csit_pkg::entry_type entry_in;

   always_comb begin
      keep     = (CW'(INDEX) < count) && (entry_ff.cost < ctrl.entry.cost);
      take_new = (ctrl.op == csit_pkg::OP_INSERT) && !keep && left_keep;
      tap      = (IW'(INDEX) == idx) ? entry_ff : '0;
      entry_in = entry_ff;
      unique case (ctrl.op)
         csit_pkg::OP_INSERT: begin
            if (keep) begin
               entry_in = entry_ff;
            end else if (left_keep) begin
               entry_in = ctrl.entry;
            end else begin
               entry_in = left_entry;
            end
         end
         csit_pkg::OP_REMOVE: begin
            if (IW'(INDEX) >= idx) begin
               entry_in = right_entry;
            end
         end
         default: entry_in = entry_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

`default_nettype wire

@@ src/csit_collect.sv @@
// ----------------------------------------------------------------------------
// csit_collect: read tap merge and insert position encoder
// ORs the one-hot read taps of all cells and encodes the one-hot insert mark.
// ----------------------------------------------------------------------------
`default_nettype none

module csit_collect #(
   parameter int CAPACITY = 128
) (
   input  csit_pkg::entry_type        taps [CAPACITY],
   input  wire [CAPACITY-1:0]         marks,
   output csit_pkg::entry_type        tap_entry,
   output logic [$clog2(CAPACITY)-1:0] position
);

   localparam int IW = $clog2(CAPACITY);

   always_comb begin
      tap_entry = '0;
      position  = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         tap_entry = tap_entry | taps[i];
         if (marks[i]) begin
            position = position | IW'(i);
         end
      end
   end

endmodule

`default_nettype wire

@@ src/cost_sorted_insert_table_top.sv @@
// ----------------------------------------------------------------------------
// cost_sorted_insert_table_top: cost ordered table as a row of cells
// Top level: command sequencer, count register and result register.
// ----------------------------------------------------------------------------
// Usage
//   Request: drive req_* and raise start; the word is taken at the edge where
//   start is high and busy is low. busy stays high until the result is out.
//   Commands: insert (cost, handle), remove at index, read at index.
//   Response: rsp_strobe is high for one cycle with position, cost, handle,
//   count and status. There is no stall on this side.
// Timing
//   Every command runs through the accept edge, the EXEC state in which all
//   cells compare against the new cost and shift in parallel, and the DONE
//   state that shows the result. A new word is taken in the cycle after the
//   strobe. The insert position comes from the one-hot mark the cells leave
//   behind; reads and removes use a one-hot tap merge.
// Reset
//   Reset clears the count and the sequencer. Cell contents are undefined
//   after reset; only slots below the count are ever read.
// ----------------------------------------------------------------------------
`default_nettype none

module cost_sorted_insert_table_top #(
   parameter int CAPACITY = 128
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         start,
   output logic        busy,
   input  wire  [1:0]  req_cmd,
   input  wire  [23:0] req_cost_in,
   input  wire  [15:0] req_handle_in,
   input  wire  [6:0]  req_index_in,
   output logic        rsp_strobe,
   output logic [6:0]  rsp_position_out,
   output logic [23:0] rsp_cost_out,
   output logic [15:0] rsp_handle_out,
   output logic [7:0]  rsp_count_out,
   output logic [1:0]  rsp_status_out
);

   localparam int IW   = $clog2(CAPACITY);
   localparam int CW   = $clog2(CAPACITY+1);
   localparam int PW   = (IW > csit_pkg::INDEX_W) ? IW : csit_pkg::INDEX_W;
   localparam int MW   = (CW > csit_pkg::COUNT_W) ? CW : csit_pkg::COUNT_W;
   localparam int CMPW = (PW > CW) ? PW : CW;

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_EXEC = 3'b010,
      S_DONE = 3'b100
   } state_type;

   state_type state_ff, state_in;

   csit_pkg::cmd_type    cmd_ff;
   csit_pkg::entry_type  new_ff;
   logic [6:0]           idx_ff;
   logic [CW-1:0]        count_ff, count_in;

   csit_pkg::status_type status_ff, status_in;
   csit_pkg::entry_type  res_ff, res_in;
   logic [6:0]           pos_ff, pos_in;
   logic                 pos_take_ff, pos_take_in;
   logic [CAPACITY-1:0]  take_ff;

   csit_pkg::cell_ctrl_type ctrl;
   logic [CW-1:0]           count_cell;
   logic [PW-1:0]           idx_wide;
   logic [IW-1:0]           idx_cell;

   csit_pkg::entry_type cell_q [CAPACITY];
   csit_pkg::entry_type tap_v  [CAPACITY];
   logic [CAPACITY-1:0] keep_v;
   logic [CAPACITY-1:0] take_v;

   csit_pkg::entry_type tap_entry;
   logic [IW-1:0]       mark_pos;
   logic [PW-1:0]       mark_pos_wide;
   logic [MW-1:0]       count_wide;

   logic full;
   logic better;
   logic in_range;
   logic accept;

   assign accept   = start && !busy;
   assign busy     = (state_ff != S_IDLE);
   assign idx_wide = PW'(idx_ff);
   assign idx_cell = idx_wide[IW-1:0];
   assign full     = (count_ff == CW'(CAPACITY));
   assign better   = new_ff.cost < cell_q[CAPACITY-1].cost;
   assign in_range = CMPW'(idx_ff) < CMPW'(count_ff);

   // command decode and result selection for the cell cycle
   always_comb begin
      ctrl.op     = csit_pkg::OP_HOLD;
      ctrl.entry  = new_ff;
      count_cell  = count_ff;
      count_in    = count_ff;
      status_in   = csit_pkg::STAT_OK;
      res_in      = '0;
      pos_in      = '0;
      pos_take_in = 1'b0;
      unique case (cmd_ff)
         csit_pkg::CMD_INSERT: begin
            if (!full) begin
               ctrl.op     = csit_pkg::OP_INSERT;
               count_in    = count_ff + CW'(1);
               pos_take_in = 1'b1;
            end else if (better) begin
               ctrl.op     = csit_pkg::OP_INSERT;
               count_cell  = CW'(CAPACITY - 1);
               status_in   = csit_pkg::STAT_EVICT;
               res_in      = cell_q[CAPACITY-1];
               pos_take_in = 1'b1;
            end else begin
               status_in = csit_pkg::STAT_REJECT;
               res_in    = new_ff;
            end
         end
         csit_pkg::CMD_REMOVE, csit_pkg::CMD_READ: begin
            pos_in = idx_ff;
            if (!in_range) begin
               status_in = csit_pkg::STAT_RANGE;
            end else begin
               res_in = tap_entry;
               if (cmd_ff == csit_pkg::CMD_REMOVE) begin
                  ctrl.op  = csit_pkg::OP_REMOVE;
                  count_in = count_ff - CW'(1);
               end
            end
         end
         default: begin
            status_in = csit_pkg::STAT_OK;
         end
      endcase
      if (state_ff != S_EXEC) begin
         ctrl.op  = csit_pkg::OP_HOLD;
         count_in = count_ff;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC:  state_in = S_DONE;
         S_DONE:  state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff <= csit_pkg::cmd_type'(req_cmd);
         new_ff <= '{cost: req_cost_in, handle: req_handle_in};
         idx_ff <= req_index_in;
      end
      if (state_ff == S_EXEC) begin
         status_ff   <= status_in;
         res_ff      <= res_in;
         pos_ff      <= pos_in;
         pos_take_ff <= pos_take_in;
         take_ff     <= take_v;
      end
   end

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      csit_pkg::entry_type left_e;
      csit_pkg::entry_type right_e;
      logic                left_k;
      if (i == 0) begin : g_first
         assign left_e = '0;
         assign left_k = 1'b1;
      end else begin : g_inner
         assign left_e = cell_q[i-1];
         assign left_k = keep_v[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign right_e = cell_q[i];
      end else begin : g_mid
         assign right_e = cell_q[i+1];
      end
      csit_cell #(
         .CAPACITY (CAPACITY),
         .INDEX    (i)
      ) u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .count       (count_cell),
         .idx         (idx_cell),
         .left_entry  (left_e),
         .left_keep   (left_k),
         .right_entry (right_e),
         .entry       (cell_q[i]),
         .keep        (keep_v[i]),
         .take_new    (take_v[i]),
         .tap         (tap_v[i])
      );
   end

   csit_collect #(
      .CAPACITY (CAPACITY)
   ) u_collect (
      .taps      (tap_v),
      .marks     (take_ff),
      .tap_entry (tap_entry),
      .position  (mark_pos)
   );

   assign mark_pos_wide    = PW'(mark_pos);
   assign count_wide       = MW'(count_ff);
   assign rsp_strobe       = (state_ff == S_DONE);
   assign rsp_position_out = pos_take_ff ? mark_pos_wide[6:0] : pos_ff;
   assign rsp_cost_out     = res_ff.cost;
   assign rsp_handle_out   = res_ff.handle;
   assign rsp_count_out    = count_wide[7:0];
   assign rsp_status_out   = status_ff;

   a_accept_runs: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == S_EXEC))
      else $error("accepted word did not start the cell cycle");

   a_strobe_frees: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !busy)
      else $error("block still busy after result");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("entry count above capacity");

   a_mark_onehot: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && pos_take_ff) |-> $onehot(take_ff))
      else $error("insert mark is not one-hot");

endmodule

`default_nettype wire
